// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the load-cell reader core. Every
// module that uses them has clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define LCAR_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LCAR_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define LCAR_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lcar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load-cell reader package
// Field widths, operation and register codes, phase encoding and the
// command/status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package lcar_pkg;

  // Fixed field widths of the request, result and configuration ports.
  localparam int OPER_W     = 3;
  localparam int OFFSET_W   = 24;
  localparam int RESULT_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register widths.
  localparam int HALF_W  = 16;
  localparam int TICK_W  = 24;
  localparam int SAMP_W  = 16;
  localparam int GAIN_W  = 32;

  // Fraction bits of the reciprocal gain.
  localparam int FRAC_BITS = 16;

  // Configuration reset values.
  localparam logic [HALF_W-1:0] HALF_RST    = 16'd10;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 24'd150000;
  localparam logic [TICK_W-1:0] SETTLE_RST  = 24'd1000000;
  localparam logic [TICK_W-1:0] GAP_RST     = 24'd5000;
  localparam logic [SAMP_W-1:0] SAMPLES_RST = 16'd10;
  localparam logic [GAIN_W-1:0] GAIN_RST    = 32'd65536;

  // Saturation limits of the signed result.
  localparam logic [RESULT_W-1:0] RESULT_MIN = 32'h8000_0000;
  localparam logic [RESULT_W-1:0] RESULT_MAX = 32'h7FFF_FFFF;

  // Operation codes carried by a request.
  typedef enum logic [OPER_W-1:0] {
    OP_TICK        = 3'd0,
    OP_AVERAGE     = 3'd1,
    OP_TARE        = 3'd2,
    OP_WEIGHT      = 3'd3,
    OP_POWER_DOWN  = 3'd4,
    OP_POWER_UP    = 3'd5,
    OP_LOAD_OFFSET = 3'd6
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_PERIOD = 3'd0,
    REG_TIMEOUT     = 3'd1,
    REG_SETTLE      = 3'd2,
    REG_GAP         = 3'd3,
    REG_SAMPLES     = 3'd4,
    REG_GAIN        = 3'd5
  } cfg_reg_t;

  // Measurement command being run.
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_AVG    = 2'd1,
    CMD_TARE   = 2'd2,
    CMD_WEIGHT = 2'd3
  } cmd_kind_t;

  // Converter sampling phase, one-hot.
  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_WAIT   = 8'b0000_0010,
    PH_SETTLE = 8'b0000_0100,
    PH_HIGH   = 8'b0000_1000,
    PH_LOW    = 8'b0001_0000,
    PH_XHIGH  = 8'b0010_0000,
    PH_XLOW   = 8'b0100_0000,
    PH_GAP    = 8'b1000_0000
  } phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic step;
    logic div_load;
    logic div_step;
    logic mul;
    logic finish;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finish_req;
    logic div_last;
  } dp_status_t;

endpackage

// ===== rtl/core/lcar_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load-cell reader request channel
// Valid/ready channel carrying one tick request: operation, data pin level
// and offset value.
// ----------------------------------------------------------------------------
interface lcar_in_if import lcar_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [OPER_W-1:0]   operation;
  logic                data_pin;
  logic [OFFSET_W-1:0] offset_value;

  modport source (output valid, operation, data_pin, offset_value, input ready);
  modport sink (input valid, operation, data_pin, offset_value, output ready);

endinterface

// ===== rtl/core/lcar_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load-cell reader result channel
// Valid/ready channel carrying one result per request: pin level, busy and
// done flags, result value and timeout flag.
// ----------------------------------------------------------------------------
interface lcar_out_if import lcar_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic                       clock_pin;
  logic                       busy_res;
  logic                       done_res;
  logic signed [RESULT_W-1:0] result_value;
  logic                       timed_out;

  modport source (output valid, clock_pin, busy_res, done_res, result_value, timed_out,
                  input ready);
  modport sink (input valid, clock_pin, busy_res, done_res, result_value, timed_out,
                output ready);

endinterface

// ===== rtl/core/lcar_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load-cell reader divider
// Restoring unsigned divider, one quotient bit per step. The dividend
// register shifts out numerator bits and shifts in quotient bits.
// ----------------------------------------------------------------------------
module lcar_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             step,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             last
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] quot_r;
  logic [DEN_W:0]   rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   rem_shift;
  logic             fits;

  // Trial subtraction of the divisor from the shifted remainder.
  assign rem_shift = {rem_r[DEN_W-1:0], quot_r[NUM_W-1]};
  assign fits      = (rem_shift >= {1'b0, den});

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (load) begin
      quot_r <= num;
      rem_r  <= '0;
    end else if (step) begin
      quot_r <= {quot_r[NUM_W-2:0], fits};
      rem_r  <= fits ? (rem_shift - {1'b0, den}) : rem_shift;
    end
  end

  assign quot = quot_r;
  assign last = (cnt_r == CNT_W'(NUM_W - 1));

endmodule

// ===== rtl/core/lcar_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Load-cell reader controller
// Sequences one request at a time through the datapath: tick update, then
// for a finished measurement the divide, multiply and result steps. Owns
// the request ready and the result valid.
// ----------------------------------------------------------------------------
module lcar_ctrl import lcar_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t sts
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b00_0001,
    ST_STEP  = 6'b00_0010,
    ST_DLOAD = 6'b00_0100,
    ST_DIV   = 6'b00_1000,
    ST_MUL   = 6'b01_0000,
    ST_FIN   = 6'b10_0000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Next state, datapath commands and handshake control.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (sts.finish_req) begin
          state_nxt = ST_DLOAD;
        end else begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish    = 1'b1;
        cmd.out_load  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A result never waits while a request is being worked on.
  `LCAR_IMPLIES(a_no_result_while_busy, state_r != ST_IDLE, !out_valid_r, "result pending while busy")
  // A request is only taken in the idle state.
  `LCAR_IMPLIES(a_ready_only_idle, in_ready, state_r == ST_IDLE, "ready outside idle")
  // The divide keeps stepping until its last quotient bit.
  `LCAR_NEXT(a_div_runs, state_r == ST_DIV && !sts.div_last, state_r == ST_DIV, "divide cut short")

endmodule

// ===== rtl/core/lcar_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Load-cell reader datapath
// Configuration registers, converter phase logic, sample accumulator,
// averaging divider, gain multiplier and the result register.
// ----------------------------------------------------------------------------
module lcar_dp import lcar_pkg::*; #(
  parameter int RAW_BITS   = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_status_t                 sts,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [OPER_W-1:0]          operation,
  input  logic                       data_pin,
  input  logic [OFFSET_W-1:0]        offset_value,
  output logic                       clock_pin,
  output logic                       busy_res,
  output logic                       done_res,
  output logic signed [RESULT_W-1:0] result_value,
  output logic                       timed_out
);

  localparam int SUM_W  = RAW_BITS + COUNT_BITS;
  localparam int BITC_W = $clog2(RAW_BITS + 1);
  localparam int PROD_W = RAW_BITS + GAIN_W;
  localparam int QW     = PROD_W - FRAC_BITS;
  localparam logic [SAMP_W-1:0] COUNT_MAX = SAMP_W'((1 << COUNT_BITS) - 1);

  // Configuration registers.
  logic [HALF_W-1:0] half_r;
  logic [TICK_W-1:0] timeout_r;
  logic [TICK_W-1:0] settle_r;
  logic [TICK_W-1:0] gap_r;
  logic [SAMP_W-1:0] samples_r;
  logic [GAIN_W-1:0] gain_r;

  // Captured request.
  logic [OPER_W-1:0]   op_r;
  logic                pin_r;
  logic [OFFSET_W-1:0] offv_r;

  // Measurement state.
  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt, tick_inc;
  logic [BITC_W-1:0]   bitc_r, bitc_nxt, bitc_inc;
  logic [RAW_BITS-1:0] shreg_r, shreg_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] taken_r, taken_nxt, taken_inc;
  logic [RAW_BITS-1:0] tare_r, tare_nxt;
  cmd_kind_t           pend_r, pend_nxt;
  logic                clk_lvl_r, clk_lvl_nxt;
  logic                tseen_r, tseen_nxt;

  // Tick helpers.
  logic                  take;
  logic [RAW_BITS-1:0]   sample_v;
  logic                  fin_req;
  logic [TICK_W-1:0]     timeout_eff;
  logic [TICK_W-1:0]     half_eff;
  logic [COUNT_BITS-1:0] count_eff;
  logic [OFFSET_W+RAW_BITS-1:0] offv_ext;

  // Finishing arithmetic.
  logic [SUM_W-1:0]        quot;
  logic                    div_last;
  logic [RAW_BITS-1:0]     avg;
  logic [RAW_BITS+31:0]    avg_ext;
  logic [RAW_BITS-1:0]     mag;
  logic                    neg_r;
  logic [PROD_W-1:0]       prod_r;
  logic [QW-1:0]           q_adj;
  logic                    round_up;
  logic [RESULT_W-1:0]     weight_res;
  logic [RESULT_W-1:0]     fin_res;

  // Output register.
  logic                clock_pin_r;
  logic                busy_res_r;
  logic                done_res_r;
  logic [RESULT_W-1:0] result_r;
  logic                timed_out_r;

  // Effective settings: zero half period and timeout act as one tick, and
  // the sample count is at least one and saturates at the counter range.
  assign timeout_eff = (timeout_r == '0) ? TICK_W'(1) : timeout_r;
  assign half_eff    = (half_r == '0) ? TICK_W'(1) : {{(TICK_W - HALF_W){1'b0}}, half_r};
  always_comb begin
    if (samples_r == '0) begin
      count_eff = COUNT_BITS'(1);
    end else if (samples_r > COUNT_MAX) begin
      count_eff = '1;
    end else begin
      count_eff = samples_r[COUNT_BITS-1:0];
    end
  end

  assign offv_ext  = {{RAW_BITS{1'b0}}, offv_r};
  assign tick_inc  = tick_r + TICK_W'(1);
  assign bitc_inc  = bitc_r + BITC_W'(1);
  assign taken_inc = taken_r + COUNT_BITS'(1);

  // One tick of the converter sequence.
  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bitc_nxt    = bitc_r;
    shreg_nxt   = shreg_r;
    sum_nxt     = sum_r;
    taken_nxt   = taken_r;
    tare_nxt    = tare_r;
    pend_nxt    = pend_r;
    clk_lvl_nxt = clk_lvl_r;
    tseen_nxt   = tseen_r;
    take        = 1'b0;
    sample_v    = '0;
    fin_req     = 1'b0;
    if (phase_r == PH_IDLE) begin
      case (op_r)
        OP_AVERAGE, OP_TARE, OP_WEIGHT: begin
          pend_nxt    = cmd_kind_t'(op_r[1:0]);
          sum_nxt     = '0;
          taken_nxt   = '0;
          tseen_nxt   = 1'b0;
          bitc_nxt    = '0;
          shreg_nxt   = '0;
          phase_nxt   = PH_WAIT;
          tick_nxt    = '0;
          clk_lvl_nxt = 1'b0;
        end
        OP_POWER_DOWN: begin
          clk_lvl_nxt = 1'b1;
        end
        OP_POWER_UP: begin
          clk_lvl_nxt = 1'b0;
        end
        OP_LOAD_OFFSET: begin
          tare_nxt = offv_ext[RAW_BITS-1:0];
        end
        default: begin
        end
      endcase
    end else begin
      case (phase_r)
        PH_WAIT: begin
          if (!pin_r) begin
            if (settle_r == '0) begin
              phase_nxt   = PH_HIGH;
              tick_nxt    = '0;
              bitc_nxt    = '0;
              shreg_nxt   = '0;
              clk_lvl_nxt = 1'b1;
            end else begin
              phase_nxt = PH_SETTLE;
              tick_nxt  = '0;
            end
          end else begin
            tick_nxt = tick_inc;
            if (tick_inc >= timeout_eff) begin
              tseen_nxt = 1'b1;
              take      = 1'b1;
            end
          end
        end
        PH_SETTLE: begin
          tick_nxt = tick_inc;
          if (tick_inc >= settle_r) begin
            phase_nxt   = PH_HIGH;
            tick_nxt    = '0;
            bitc_nxt    = '0;
            shreg_nxt   = '0;
            clk_lvl_nxt = 1'b1;
          end
        end
        PH_HIGH, PH_XHIGH: begin
          tick_nxt = tick_inc;
          if (tick_inc >= half_eff) begin
            clk_lvl_nxt = 1'b0;
            tick_nxt    = '0;
            phase_nxt   = (phase_r == PH_HIGH) ? PH_LOW : PH_XLOW;
          end
        end
        PH_LOW: begin
          tick_nxt = tick_inc;
          if (tick_inc >= half_eff) begin
            shreg_nxt   = {shreg_r[RAW_BITS-2:0], pin_r};
            bitc_nxt    = bitc_inc;
            tick_nxt    = '0;
            clk_lvl_nxt = 1'b1;
            phase_nxt   = (bitc_inc >= BITC_W'(RAW_BITS)) ? PH_XHIGH : PH_HIGH;
          end
        end
        PH_XLOW: begin
          tick_nxt = tick_inc;
          if (tick_inc >= half_eff) begin
            take     = 1'b1;
            sample_v = shreg_r ^ {1'b1, {(RAW_BITS - 1){1'b0}}};
          end
        end
        PH_GAP: begin
          tick_nxt = tick_inc;
          if (tick_inc >= gap_r) begin
            phase_nxt   = PH_WAIT;
            tick_nxt    = '0;
            clk_lvl_nxt = 1'b0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    // Accumulate a finished or timed-out sample.
    if (take) begin
      sum_nxt     = sum_r + SUM_W'(sample_v);
      taken_nxt   = taken_inc;
      clk_lvl_nxt = 1'b0;
      if (taken_inc >= count_eff) begin
        fin_req = 1'b1;
      end else if (gap_r == '0) begin
        phase_nxt = PH_WAIT;
        tick_nxt  = '0;
      end else begin
        phase_nxt = PH_GAP;
        tick_nxt  = '0;
      end
    end
  end

  // Average of the samples.
  lcar_div #(
    .NUM_W (SUM_W),
    .DEN_W (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cmd.div_load),
    .step  (cmd.div_step),
    .num   (sum_r),
    .den   (count_eff),
    .quot  (quot),
    .last  (div_last)
  );

  assign avg     = quot[RAW_BITS-1:0];
  assign avg_ext = {32'd0, avg};
  assign mag     = (avg < tare_r) ? (tare_r - avg) : (avg - tare_r);

  // Gain product, registered before rounding and saturation.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      neg_r  <= (avg < tare_r);
      prod_r <= PROD_W'(mag) * PROD_W'(gain_r);
    end
  end

  // Shift out the fraction rounding toward minus infinity, then saturate.
  assign round_up = neg_r && (prod_r[FRAC_BITS-1:0] != '0);
  assign q_adj    = prod_r[PROD_W-1:FRAC_BITS] + QW'(round_up);
  always_comb begin
    if (|q_adj[QW-1:RESULT_W-1]) begin
      weight_res = neg_r ? RESULT_MIN : RESULT_MAX;
    end else begin
      weight_res = neg_r ? (RESULT_W'(0) - q_adj[RESULT_W-1:0]) : q_adj[RESULT_W-1:0];
    end
  end

  assign fin_res = (pend_r == CMD_WEIGHT) ? weight_res : avg_ext[RESULT_W-1:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= HALF_RST;
      timeout_r <= TIMEOUT_RST;
      settle_r  <= SETTLE_RST;
      gap_r     <= GAP_RST;
      samples_r <= SAMPLES_RST;
      gain_r    <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_PERIOD: half_r    <= cfg_wdata[HALF_W-1:0];
        REG_TIMEOUT:     timeout_r <= cfg_wdata[TICK_W-1:0];
        REG_SETTLE:      settle_r  <= cfg_wdata[TICK_W-1:0];
        REG_GAP:         gap_r     <= cfg_wdata[TICK_W-1:0];
        REG_SAMPLES:     samples_r <= cfg_wdata[SAMP_W-1:0];
        REG_GAIN:        gain_r    <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= operation;
      pin_r  <= data_pin;
      offv_r <= offset_value;
    end
  end

  // Measurement state: tick update, or the close of a finished command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      bitc_r    <= '0;
      shreg_r   <= '0;
      sum_r     <= '0;
      taken_r   <= '0;
      tare_r    <= '0;
      pend_r    <= CMD_NONE;
      clk_lvl_r <= 1'b0;
      tseen_r   <= 1'b0;
    end else if (cmd.step) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bitc_r    <= bitc_nxt;
      shreg_r   <= shreg_nxt;
      sum_r     <= sum_nxt;
      taken_r   <= taken_nxt;
      tare_r    <= tare_nxt;
      pend_r    <= pend_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      tseen_r   <= tseen_nxt;
    end else if (cmd.finish) begin
      phase_r <= PH_IDLE;
      pend_r  <= CMD_NONE;
      tick_r  <= '0;
      if (pend_r == CMD_TARE) begin
        tare_r <= avg;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.finish) begin
        clock_pin_r <= clk_lvl_r;
        busy_res_r  <= 1'b0;
        done_res_r  <= 1'b1;
        result_r    <= fin_res;
        timed_out_r <= tseen_r;
      end else begin
        clock_pin_r <= clk_lvl_nxt;
        busy_res_r  <= (phase_nxt != PH_IDLE);
        done_res_r  <= 1'b0;
        result_r    <= '0;
        timed_out_r <= 1'b0;
      end
    end
  end

  assign clock_pin    = clock_pin_r;
  assign busy_res     = busy_res_r;
  assign done_res     = done_res_r;
  assign result_value = result_r;
  assign timed_out    = timed_out_r;

  assign sts.finish_req = fin_req;
  assign sts.div_last   = div_last;

  // A command only closes while a measurement is running.
  `LCAR_IMPLIES(a_finish_busy, cmd.finish, phase_r != PH_IDLE, "finish while idle")
  // The high halves of a clock pulse drive the pin high, the low halves low.
  `LCAR_IMPLIES(a_high_level, phase_r == PH_HIGH || phase_r == PH_XHIGH, clk_lvl_r, "pin low in high half")
  `LCAR_IMPLIES(a_low_level, phase_r == PH_LOW || phase_r == PH_XLOW, !clk_lvl_r, "pin high in low half")

endmodule

// ===== rtl/core/load_cell_adc_reader_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load-cell converter reader
// Drives the serial clock of a bridge converter and reads its data pin, one
// tick per request, with averaging, tare and Q16 gain scaling.
// ----------------------------------------------------------------------------
// Usage: each request on in_ch is one tick: an operation, the data pin level
// seen this tick and an offset for the load-offset operation. For every
// request exactly one result leaves on out_ch with the clock pin level, busy
// and done flags and, on the tick that ends a measurement, the value and the
// timeout flag. Registers are written through cfg_we/cfg_index/cfg_wdata
// while no request is in work.
// Sequence: a plain tick request is captured, stepped and its result loaded
// into the output register before the next request is taken. The tick that
// ends a measurement runs the averaging divide, one quotient bit per cycle
// over RAW_BITS+COUNT_BITS bits, then the gain multiply, before its result
// is loaded.
// Reset (synchronous, rst_n low) loads the register defaults, idles the
// sequence, clears the tare offset and sets the internal clock level low.
// A stalled receiver holds the result in the output register; one further
// request is taken only in the cycle the held result is taken.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_core import lcar_pkg::*; #(
  parameter int RAW_BITS   = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lcar_in_if.sink               in_ch,
  lcar_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Sequencer.
  lcar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Converter sequence, arithmetic and result register.
  lcar_dp #(
    .RAW_BITS   (RAW_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .operation    (in_ch.operation),
    .data_pin     (in_ch.data_pin),
    .offset_value (in_ch.offset_value),
    .clock_pin    (out_ch.clock_pin),
    .busy_res     (out_ch.busy_res),
    .done_res     (out_ch.done_res),
    .result_value (out_ch.result_value),
    .timed_out    (out_ch.timed_out)
  );

endmodule

// ===== bench/tb_load_cell_adc_reader_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load-cell reader core testbench
// Feeds tick requests through the request channel and checks every result
// against a cycle-free model of the converter sampling sequence, averaging,
// tare and Q16 weight scaling. Measurements are built as well-formed pin
// sequences with random content, mixed with ignored requests and noise,
// across several register settings including their extremes. Both channel
// sides idle at random, and once the receiver stalls for a long stretch.
// ----------------------------------------------------------------------------
module tb_load_cell_adc_reader_core;
  import lcar_pkg::*;

  // Bench constants.
  localparam int             RAW_W       = 24;
  localparam logic [23:0]    SIGN_FLIP   = 24'h80_0000;
  localparam logic [OPER_W-1:0] OP_UNUSED = 3'd7;
  localparam int             ITEMS_GOAL  = 1400;
  localparam int             DONE_GOAL   = 20;
  localparam int             HOLD_AT     = 500;
  localparam int             HOLD_CYCLES = 300;
  localparam int             TAIL_CYCLES = 60;
  localparam int             LIMIT_NS    = 12_000_000;

  // Stimulus modes of one run of requests.
  typedef enum logic [1:0] {
    MODE_FULL,
    MODE_TIMEOUT_ONLY,
    MODE_IDLE_ONLY
  } stim_mode_t;

  typedef struct packed {
    logic [OPER_W-1:0]   op;
    logic                pin;
    logic [OFFSET_W-1:0] offset;
  } tick_req_t;

  typedef struct packed {
    logic                clock_pin;
    logic                busy;
    logic                done;
    logic [RESULT_W-1:0] value;
    logic                timed_out;
  } reading_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lcar_in_if  in_ch ();
  lcar_out_if out_ch ();

  load_cell_adc_reader_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register shadows, loaded with the reset values.
  logic [HALF_W-1:0] half_q    = HALF_RST;
  logic [TICK_W-1:0] timeout_q = TIMEOUT_RST;
  logic [TICK_W-1:0] settle_q  = SETTLE_RST;
  logic [TICK_W-1:0] gap_q     = GAP_RST;
  logic [SAMP_W-1:0] samples_q = SAMPLES_RST;
  logic [GAIN_W-1:0] gain_q    = GAIN_RST;

  // Sampling sequence state of the model.
  phase_t      ph       = PH_IDLE;
  cmd_kind_t   pend     = CMD_NONE;
  int unsigned tick_cnt = 0;
  int unsigned bit_cnt  = 0;
  int unsigned taken    = 0;
  logic [23:0] shreg    = '0;
  logic [39:0] acc      = '0;
  logic [23:0] tare     = '0;
  logic        clk_lvl  = 1'b0;
  logic        to_seen  = 1'b0;

  // Queues and counters.
  tick_req_t  tick_reqs[$];
  reading_t   expected_readings[$];
  int         reqs_queued   = 0;
  int         reqs_taken    = 0;
  int         results_seen  = 0;
  int         measures_done = 0;
  int         errors        = 0;
  bit         req_taken     = 1'b0;
  bit         gaps_on       = 1'b1;
  int         hold_left     = 0;
  bit         hold_done     = 1'b0;
  stim_mode_t mode          = MODE_FULL;

  // Clock and reset.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_HALF_PERIOD;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_TICK;
    in_ch.data_pin      = 1'b0;
    in_ch.offset_value  = '0;
    out_ch.ready        = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #LIMIT_NS;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Zero settings act as one.
  function automatic int unsigned eff_half();
    return (half_q == 0) ? 1 : half_q;
  endfunction

  function automatic int unsigned eff_timeout();
    return (timeout_q == 0) ? 1 : timeout_q;
  endfunction

  function automatic int unsigned eff_count();
    return (samples_q == 0) ? 1 : samples_q;
  endfunction

  function automatic void start_wait();
    ph       = PH_WAIT;
    tick_cnt = 0;
    clk_lvl  = 1'b0;
  endfunction

  function automatic void start_clock();
    ph       = PH_HIGH;
    tick_cnt = 0;
    bit_cnt  = 0;
    shreg    = '0;
    clk_lvl  = 1'b1;
  endfunction

  // Divides the sum down and forms the value for the running command.
  function automatic logic [RESULT_W-1:0] close_measure();
    logic [39:0]         avg;
    logic [63:0]         mag;
    logic [63:0]         prod;
    logic [63:0]         q;
    logic                neg;
    logic [RESULT_W-1:0] r;
    avg = acc / 40'(eff_count());
    case (pend)
      CMD_AVG: r = avg[31:0];
      CMD_TARE: begin
        tare = avg[23:0];
        r    = {8'd0, tare};
      end
      default: begin
        neg  = avg < {16'd0, tare};
        mag  = neg ? (64'(tare) - 64'(avg)) : (64'(avg) - 64'(tare));
        prod = mag * 64'(gain_q);
        q    = prod >> FRAC_BITS;
        if (neg) begin
          // Floor of a negative value rounds the magnitude up.
          if (prod[FRAC_BITS-1:0] != 0) q = q + 1;
          r = (q >= 64'h8000_0000) ? RESULT_MIN : (32'd0 - q[31:0]);
        end else begin
          r = (q > 64'h7FFF_FFFF) ? RESULT_MAX : q[31:0];
        end
      end
    endcase
    ph       = PH_IDLE;
    pend     = CMD_NONE;
    tick_cnt = 0;
    return r;
  endfunction

  // Adds one sample; returns 1 when the command is complete.
  function automatic bit add_sample(logic [23:0] v);
    acc     = acc + {16'd0, v};
    taken   = taken + 1;
    clk_lvl = 1'b0;
    if (taken >= eff_count()) return 1'b1;
    if (gap_q == 0) begin
      start_wait();
    end else begin
      ph       = PH_GAP;
      tick_cnt = 0;
    end
    return 1'b0;
  endfunction

  // One tick of the sampling sequence while a command runs.
  function automatic bit step_phase(logic pin);
    case (ph)
      PH_WAIT: begin
        if (!pin) begin
          if (settle_q == 0) begin
            start_clock();
          end else begin
            ph       = PH_SETTLE;
            tick_cnt = 0;
          end
          return 1'b0;
        end
        tick_cnt = tick_cnt + 1;
        if (tick_cnt >= eff_timeout()) begin
          to_seen = 1'b1;
          return add_sample('0);
        end
        return 1'b0;
      end
      PH_SETTLE: begin
        tick_cnt = tick_cnt + 1;
        if (tick_cnt >= settle_q) start_clock();
        return 1'b0;
      end
      PH_HIGH, PH_XHIGH: begin
        tick_cnt = tick_cnt + 1;
        if (tick_cnt >= eff_half()) begin
          clk_lvl  = 1'b0;
          tick_cnt = 0;
          ph       = (ph == PH_HIGH) ? PH_LOW : PH_XLOW;
        end
        return 1'b0;
      end
      PH_LOW: begin
        tick_cnt = tick_cnt + 1;
        if (tick_cnt >= eff_half()) begin
          shreg    = {shreg[22:0], pin};
          bit_cnt  = bit_cnt + 1;
          tick_cnt = 0;
          clk_lvl  = 1'b1;
          ph       = (bit_cnt >= RAW_W) ? PH_XHIGH : PH_HIGH;
        end
        return 1'b0;
      end
      PH_XLOW: begin
        tick_cnt = tick_cnt + 1;
        if (tick_cnt >= eff_half()) return add_sample(shreg ^ SIGN_FLIP);
        return 1'b0;
      end
      PH_GAP: begin
        tick_cnt = tick_cnt + 1;
        if (tick_cnt >= gap_q) start_wait();
        return 1'b0;
      end
      default: begin
        ph = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // Works out the reading that one accepted request produces.
  function automatic reading_t predict_tick(tick_req_t rq);
    reading_t rd;
    rd = '0;
    if (ph == PH_IDLE) begin
      case (rq.op)
        OP_AVERAGE, OP_TARE, OP_WEIGHT: begin
          pend    = cmd_kind_t'(rq.op[1:0]);
          acc     = '0;
          taken   = 0;
          to_seen = 1'b0;
          bit_cnt = 0;
          shreg   = '0;
          start_wait();
        end
        OP_POWER_DOWN:  clk_lvl = 1'b1;
        OP_POWER_UP:    clk_lvl = 1'b0;
        OP_LOAD_OFFSET: tare = rq.offset;
        default: ;
      endcase
    end else if (step_phase(rq.pin)) begin
      rd.timed_out  = to_seen;
      rd.value      = close_measure();
      rd.done       = 1'b1;
      measures_done = measures_done + 1;
    end
    rd.clock_pin = clk_lvl;
    rd.busy      = (ph != PH_IDLE);
    return rd;
  endfunction

  // Request side: record acceptance and queue the expected reading.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken = 1'b0;
    end else begin
      req_taken = in_ch.valid && in_ch.ready;
      if (req_taken) begin
        expected_readings.push_back(predict_tick({in_ch.operation, in_ch.data_pin,
                                                  in_ch.offset_value}));
        reqs_taken = reqs_taken + 1;
      end
    end
  end

  // Request driver: presents the next pending request, with random gaps.
  always @(negedge clk) begin : feed
    tick_req_t nx;
    logic      nv;
    nv = in_ch.valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_ch.valid || req_taken) begin
      nv = 1'b0;
      if (tick_reqs.size() != 0 && !(gaps_on && $urandom_range(99) < 35)) begin
        nx = tick_reqs.pop_front();
        nv = 1'b1;
        in_ch.operation    <= nx.op;
        in_ch.data_pin     <= nx.pin;
        in_ch.offset_value <= nx.offset;
      end
    end
    in_ch.valid <= nv;
  end

  // Result receiver: random stalls plus one long hold-off.
  always @(negedge clk) begin : drain
    logic rdy;
    if (!hold_done && reqs_taken >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rdy       = 1'b0;
    end else if (gaps_on) begin
      rdy = ($urandom_range(99) >= 35);
    end else begin
      rdy = 1'b1;
    end
    out_ch.ready <= rdy;
  end

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors = errors + 1;
    end
  endtask

  // Result monitor: compares each result with the oldest expectation.
  always @(posedge clk) begin : watch
    reading_t ex;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen = results_seen + 1;
      if (expected_readings.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %h",
                 $time, out_ch.result_value);
        errors = errors + 1;
      end else begin
        ex = expected_readings.pop_front();
        report_field("clock_pin", 32'(ex.clock_pin), 32'(out_ch.clock_pin));
        report_field("busy_res", 32'(ex.busy), 32'(out_ch.busy_res));
        report_field("done_res", 32'(ex.done), 32'(out_ch.done_res));
        report_field("result_value", ex.value, out_ch.result_value);
        report_field("timed_out", 32'(ex.timed_out), 32'(out_ch.timed_out));
      end
    end
  end

  task automatic push_tick(logic [OPER_W-1:0] op, logic pin, logic [OFFSET_W-1:0] off);
    tick_reqs.push_back({op, pin, off});
    reqs_queued = reqs_queued + 1;
  endtask

  // Mostly plain ticks; any code is ignored while a command runs.
  function automatic logic [OPER_W-1:0] busy_op();
    if ($urandom_range(99) < 80) return OP_TICK;
    return OPER_W'($urandom_range(OP_UNUSED, OP_TICK));
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return OFFSET_W'($urandom);
    endcase
  endfunction

  // Raw words biased toward the extremes of the flipped sample.
  function automatic logic [23:0] pick_word();
    case ($urandom_range(7))
      0:       return 24'h7F_FFFF;
      1:       return 24'h80_0000;
      2:       return 24'hFF_FFFF;
      3:       return 24'h00_0000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (results_seen < reqs_queued) @(negedge clk);
  endtask

  // Runs ticks with the data pin high until the model is idle again.
  task automatic settle_idle();
    wait_drained();
    while (ph != PH_IDLE) begin
      push_tick(OP_TICK, 1'b1, pick_offset());
      wait_drained();
    end
  endtask

  // Requests accepted while idle that start no measurement.
  task automatic idle_noise();
    logic [OPER_W-1:0] op;
    int                n;
    n = $urandom_range(4, 1);
    repeat (n) begin
      case ($urandom_range(4))
        0:       op = OP_POWER_DOWN;
        1:       op = OP_POWER_UP;
        2:       op = OP_LOAD_OFFSET;
        3:       op = OP_UNUSED;
        default: op = OP_TICK;
      endcase
      push_tick(op, 1'($urandom), pick_offset());
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_HALF_PERIOD: half_q    = val[HALF_W-1:0];
      REG_TIMEOUT:     timeout_q = val[TICK_W-1:0];
      REG_SETTLE:      settle_q  = val[TICK_W-1:0];
      REG_GAP:         gap_q     = val[TICK_W-1:0];
      REG_SAMPLES:     samples_q = val[SAMP_W-1:0];
      default:         gain_q    = val[GAIN_W-1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int unsigned h, int unsigned to, int unsigned st,
                            int unsigned gp, int unsigned ns, logic [31:0] gn);
    settle_idle();
    write_reg(REG_HALF_PERIOD, h);
    write_reg(REG_TIMEOUT, to);
    write_reg(REG_SETTLE, st);
    write_reg(REG_GAP, gp);
    write_reg(REG_SAMPLES, ns);
    write_reg(REG_GAIN, gn);
  endtask

  // One well-formed measurement: each sample either times out or sees the
  // pin go low, settles, and gets a chosen word on the sampled ticks.
  task automatic measure_cmd(logic [OPER_W-1:0] cmd);
    int unsigned h;
    int unsigned to;
    int unsigned n;
    int unsigned w;
    logic [23:0] word;
    h  = eff_half();
    to = eff_timeout();
    n  = eff_count();
    settle_idle();
    idle_noise();
    push_tick(cmd, 1'($urandom), pick_offset());
    for (int unsigned i = 0; i < n; i++) begin
      if (mode == MODE_TIMEOUT_ONLY || $urandom_range(99) < 12) begin
        repeat (to) push_tick(busy_op(), 1'b1, pick_offset());
      end else begin
        w = $urandom_range(to - 1, 0);
        repeat (w) push_tick(busy_op(), 1'b1, pick_offset());
        push_tick(busy_op(), 1'b0, pick_offset());
        repeat (settle_q) push_tick(busy_op(), 1'($urandom), pick_offset());
        word = pick_word();
        for (int k = RAW_W - 1; k >= 0; k--) begin
          repeat (2 * h - 1) push_tick(busy_op(), 1'($urandom), pick_offset());
          push_tick(busy_op(), word[k], pick_offset());
        end
        // Extra pulse after the last bit.
        repeat (2 * h) push_tick(busy_op(), 1'($urandom), pick_offset());
      end
      if (i + 1 < n) repeat (gap_q) push_tick(busy_op(), 1'($urandom), pick_offset());
    end
  endtask

  // A command followed by fully random ticks, cut off anywhere.
  task automatic noise_burst();
    int n;
    settle_idle();
    n = $urandom_range(80, 10);
    push_tick(OPER_W'($urandom_range(OP_WEIGHT, OP_AVERAGE)), 1'($urandom), pick_offset());
    repeat (n) push_tick(OPER_W'($urandom), 1'($urandom), pick_offset());
  endtask

  task automatic run_phase(stim_mode_t m, int target);
    int start;
    mode  = m;
    start = reqs_queued;
    while (reqs_queued - start < target) begin
      if (m == MODE_IDLE_ONLY) begin
        idle_noise();
      end else if (m == MODE_FULL && $urandom_range(99) < 15) begin
        noise_burst();
      end else begin
        measure_cmd(OPER_W'($urandom_range(OP_WEIGHT, OP_AVERAGE)));
      end
    end
    mode = MODE_FULL;
  endtask

  // Stimulus sequence.
  initial begin : stim
    logic [31:0] gn;
    @(posedge rst_n);
    set_config(1, 4, 0, 0, 1, 32'h0001_0000);

    // Directed: every operation, the ignored code, offsets at both ends,
    // requests ignored while busy, and timed-out samples for each command.
    push_tick(OP_POWER_DOWN, 1'b0, '0);
    push_tick(OP_TICK, 1'b0, '0);
    push_tick(OP_POWER_UP, 1'b1, '1);
    push_tick(OP_UNUSED, 1'b1, '1);
    push_tick(OP_LOAD_OFFSET, 1'b0, '1);
    push_tick(OP_AVERAGE, 1'b1, '0);
    push_tick(OP_TARE, 1'b1, '0);
    push_tick(OP_POWER_DOWN, 1'b1, '0);
    push_tick(OP_LOAD_OFFSET, 1'b1, '0);
    push_tick(OP_UNUSED, 1'b1, '0);
    push_tick(OP_WEIGHT, 1'b1, '0);
    repeat (4) push_tick(OP_TICK, 1'b1, '0);
    push_tick(OP_POWER_DOWN, 1'b0, '0);
    push_tick(OP_TARE, 1'b1, '0);
    repeat (4) push_tick(OP_WEIGHT, 1'b1, '0);
    push_tick(OP_LOAD_OFFSET, 1'b0, '0);

    run_phase(MODE_FULL, 150);
    set_config(0, 3, 2, 1, 2, 32'h0001_8000);
    run_phase(MODE_FULL, 150);

    // A stretch with no idling on either side.
    gaps_on = 1'b0;
    set_config(2, 6, 5, 3, 3, $urandom);
    run_phase(MODE_FULL, 150);
    gaps_on = 1'b1;

    set_config(1, 1, 0, 0, 0, 32'hFFFF_FFFF);
    run_phase(MODE_FULL, 150);
    set_config(3, 10, 1, 4, 4, 32'h0000_0000);
    run_phase(MODE_FULL, 150);

    // Largest half period, settle and gap with a zero timeout: only timed-out samples keep these short.
    set_config(16'hFFFF, 0, 24'hFF_FFFF, 24'hFF_FFFF, 1, 32'hFFFF_FFFF);
    run_phase(MODE_TIMEOUT_ONLY, 60);

    // Largest sample count and timeout, exercised with idle requests only.
    set_config(1, 24'hFF_FFFF, 0, 0, 16'hFFFF, 32'h0001_0000);
    run_phase(MODE_IDLE_ONLY, 40);

    // Random small timing and count settings until enough requests have run and enough measurements have completed.
    while (reqs_queued < ITEMS_GOAL || measures_done < DONE_GOAL) begin
      case ($urandom_range(3))
        0:       gn = 32'h0000_0000;
        1:       gn = 32'hFFFF_FFFF;
        2:       gn = 32'($urandom_range(32'h0004_0000, 32'h0000_4000));
        default: gn = $urandom;
      endcase
      set_config($urandom_range(3, 0), $urandom_range(8, 1), $urandom_range(6, 0),
                 $urandom_range(6, 0), $urandom_range(4, 0), gn);
      run_phase(MODE_FULL, 150);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_readings.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               expected_readings.size());
      errors = errors + 1;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
